FILE: src/ptioc_pkg.sv
// ----------------------------------------------------------------------------
// Per-tag in-order completion: shared package
// Result codes, action codes, the queued item and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptioc_pkg;

    localparam int IN_TAG_W = 3;
    localparam int IN_ID_W  = 16;
    localparam int MAX_RELEASE = 8;

    typedef enum logic [1:0] {
        KIND_ASSIGN  = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic {
        ACT_DISPATCH = 1'b0,
        ACT_COMPLETE = 1'b1
    } action_t;

    typedef struct packed {
        action_t               action;
        logic                  tag_ok;
        logic [IN_TAG_W-1:0]   tag;
        logic [IN_ID_W-1:0]    task_id;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_REL_RD,
        ST_REL_OUT,
        ST_ERR
    } state_t;

endpackage

`default_nettype wire

FILE: src/ptioc_front.sv
// ----------------------------------------------------------------------------
// Per-tag in-order completion: front end
// Accepts input items, checks the tag range and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptioc_front #(
    parameter int TAG_COUNT = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   action,
    input  wire logic [2:0]             tag,
    input  wire logic [15:0]            task_id,
    output logic                        q_valid,
    output ptioc_pkg::item_t            q_item,
    input  wire logic                   q_pop
);
    import ptioc_pkg::*;

    item_t      fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    item_t      new_item;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.action  = action_t'(action);
        new_item.tag_ok  = (32'(tag) < TAG_COUNT);
        new_item.tag     = tag;
        new_item.task_id = task_id;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ptioc_back.sv
// ----------------------------------------------------------------------------
// Per-tag in-order completion: back end
// Sequencer that owns the per-tag queues, searches for completed ids one
// entry at a time and releases finished entries in dispatch order.
// ----------------------------------------------------------------------------
`default_nettype none

module ptioc_back #(
    parameter int TAG_COUNT     = 8,
    parameter int PER_TAG_DEPTH = 8,
    parameter int ID_BITS       = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire ptioc_pkg::item_t   q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic [2:0]              out_tag,
    output logic [15:0]             out_id,
    output logic                    last
);
    import ptioc_pkg::*;

    localparam int SLOTS  = TAG_COUNT * PER_TAG_DEPTH;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TIDX_W = $clog2(TAG_COUNT);
    localparam int POS_W  = (PER_TAG_DEPTH > 1) ? $clog2(PER_TAG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PER_TAG_DEPTH + 1);
    localparam int N_W    = $clog2(MAX_RELEASE);

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [POS_W:0] s;
        s = (POS_W + 1)'(a) + (POS_W + 1)'(b);
        if (s >= (POS_W + 1)'(PER_TAG_DEPTH))
        begin
            s = s - (POS_W + 1)'(PER_TAG_DEPTH);
        end
        return POS_W'(s);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [TIDX_W-1:0] t,
                                                  input logic [POS_W-1:0] p);
        return SLOT_W'(32'(t) * PER_TAG_DEPTH + 32'(p));
    endfunction

    logic [ID_BITS-1:0] pend_mem [SLOTS];
    logic [ID_BITS-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_addr;

    logic [SLOTS-1:0]   done_reg;
    logic [POS_W-1:0]   head_reg [TAG_COUNT];
    logic [CNT_W-1:0]   cnt_reg  [TAG_COUNT];
    logic [ID_BITS-1:0] next_id_reg;

    state_t             state_reg;
    state_t             state_next;
    item_t              cur_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_next;
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     n_next;

    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [2:0]         out_tag_reg;
    logic [15:0]        out_id_reg;
    logic               last_reg;

    logic [TIDX_W-1:0]  tidx;
    logic [ID_BITS-1:0] tid;
    logic [POS_W-1:0]   cur_head;
    logic [CNT_W-1:0]   cur_cnt;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  next_slot;
    logic [SLOT_W-1:0]  srch_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic               out_free;

    logic               emit;
    kind_t              emit_kind;
    logic [15:0]        emit_id;
    logic               emit_last;
    logic               do_dispatch;
    logic               do_mark;
    logic               do_release;

    assign tidx      = TIDX_W'(cur_reg.tag);
    assign tid       = ID_BITS'(cur_reg.task_id);
    assign cur_head  = head_reg[tidx];
    assign cur_cnt   = cnt_reg[tidx];
    assign head_slot = slot_of(tidx, cur_head);
    assign next_slot = slot_of(tidx, pos_add(cur_head, CNT_W'(1)));
    assign srch_slot = slot_of(tidx, pos_add(cur_head, k_reg));
    assign tail_slot = slot_of(tidx, pos_add(cur_head, cur_cnt));
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_tag   = out_tag_reg;
    assign out_id    = out_id_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_ERROR;
        emit_id     = 16'd0;
        emit_last   = 1'b1;
        do_dispatch = 1'b0;
        do_mark     = 1'b0;
        do_release  = 1'b0;
        rd_addr     = head_slot;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!cur_reg.tag_ok)
                begin
                    state_next = ST_ERR;
                end
                else if (cur_reg.action == ACT_COMPLETE)
                begin
                    k_next     = '0;
                    state_next = ST_SRCH_RD;
                end
                else if (cur_cnt >= CNT_W'(PER_TAG_DEPTH))
                begin
                    state_next = ST_ERR;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_ASSIGN;
                    emit_id     = 16'(next_id_reg);
                    do_dispatch = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SRCH_RD:
            begin
                rd_addr = srch_slot;
                if (k_reg == cur_cnt)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                rd_addr = srch_slot;
                if (rd_data_reg == tid && !done_reg[srch_slot])
                begin
                    do_mark    = 1'b1;
                    n_next     = '0;
                    state_next = ST_REL_RD;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_REL_RD:
            begin
                if (cur_cnt == '0 || !done_reg[head_slot])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_REL_OUT;
                end
            end
            ST_REL_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_RELEASE;
                    emit_id    = 16'(rd_data_reg);
                    emit_last  = (cur_cnt == CNT_W'(1)) ||
                                 (n_reg == N_W'(MAX_RELEASE - 1)) ||
                                 !done_reg[next_slot];
                    do_release = 1'b1;
                    n_next     = n_reg + N_W'(1);
                    state_next = emit_last ? ST_IDLE : ST_REL_RD;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                    emit_id    = (cur_reg.action == ACT_COMPLETE) ? 16'(tid) : 16'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= pend_mem[rd_addr];
        if (do_dispatch)
        begin
            pend_mem[tail_slot] <= next_id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (emit)
        begin
            kind_reg    <= emit_kind;
            out_tag_reg <= cur_reg.tag;
            out_id_reg  <= emit_id;
            last_reg    <= emit_last;
        end
        k_reg <= k_next;
        n_reg <= n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            next_id_reg   <= '0;
            for (int i = 0; i < TAG_COUNT; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_dispatch)
            begin
                done_reg[tail_slot] <= 1'b0;
                cnt_reg[tidx]       <= cur_cnt + CNT_W'(1);
                next_id_reg         <= next_id_reg + ID_BITS'(1);
            end
            if (do_mark)
            begin
                done_reg[srch_slot] <= 1'b1;
            end
            if (do_release)
            begin
                done_reg[head_slot] <= 1'b0;
                head_reg[tidx]      <= pos_add(cur_head, CNT_W'(1));
                cnt_reg[tidx]       <= cur_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/per_tag_in_order_completion.sv
// ----------------------------------------------------------------------------
// Per-tag in-order completion
// Hands out sequence ids to dispatched tasks and releases completed tasks in
// dispatch order within each tag.
//
// The input channel (in_valid, in_stall) carries one item: a dispatch or a
// completion for a tag. The output channel (out_valid, out_stall) carries
// result items; last marks the final result of an input item. A completion
// whose queue head is not yet done gives no result.
// A two-entry queue sits in front of the sequencer, so input is taken while
// a result waits. A dispatch to a full tag queue gives an error. The pending
// ids sit in a memory with one read port, so a completion searches its tag
// queue one entry at a time, reading then comparing each, and reads each
// released entry before sending it; an unknown id gives an error once every
// held entry is searched. At most eight entries are released per completion.
// Reset empties every queue, clears all done marks and restarts ids at zero.
// While out_stall is high a held result stays in the result register and
// the sequencer waits before its next result; the input queue then fills
// and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module per_tag_in_order_completion #(
    parameter int TAG_COUNT     = 8,
    parameter int PER_TAG_DEPTH = 8,
    parameter int ID_BITS       = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [2:0]  tag,
    input  wire logic [15:0] task_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [2:0]       out_tag,
    output logic [15:0]      out_id,
    output logic             last
);
    import ptioc_pkg::*;

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    ptioc_front #(
        .TAG_COUNT(TAG_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action  (action),
        .tag     (tag),
        .task_id (task_id),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    ptioc_back #(
        .TAG_COUNT    (TAG_COUNT),
        .PER_TAG_DEPTH(PER_TAG_DEPTH),
        .ID_BITS      (ID_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .out_tag  (out_tag),
        .out_id   (out_id),
        .last     (last)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-tag in-order completion block
// A queue of items (dispatches and completions) is filled up front and driven
// in bursts, while the result side stalls in changing patterns. A behavioural
// model of the tag queues predicts every result, which is checked field by
// field. The run covers full queues, unknown and repeated completions and
// long releases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import ptioc_pkg::*;

    localparam int TAGS  = 8;
    localparam int DEPTH = 8;
    localparam int SLOTS = TAGS * DEPTH;
    localparam int LIMIT = 4000000;
    localparam int DRAIN = 64;

    typedef struct {
        action_t     action;
        logic [2:0]  tag;
        logic [15:0] task_id;
        bit          rush;
    } job_t;

    typedef struct {
        kind_t       kind;
        logic [2:0]  tag;
        logic [15:0] id;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [2:0]  tag = 3'd0;
    logic [15:0] task_id = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [2:0]  out_tag;
    logic [15:0] out_id;
    logic        last;

    // Index 0 shadows the block while items are generated, index 1 follows
    // the items as they are accepted.
    logic [15:0] slot_id [2][SLOTS];
    bit          slot_done [2][SLOTS];
    int          q_head [2][TAGS];
    int          q_cnt [2][TAGS];
    logic [15:0] next_seq [2];

    job_t    job_q [$];
    result_t expected_q [$];
    int      errors = 0;
    int      cycles = 0;
    bit      holding = 0;
    bit      took = 0;
    bit      rush = 0;
    int      burst_left = 1;
    int      gap_left = 0;
    int      mode = 0;
    int      mode_left = 0;

    per_tag_in_order_completion uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .tag       (tag),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_tag   (out_tag),
        .out_id    (out_id),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void tag_queue_step(int m, action_t a, logic [2:0] t, logic [15:0] id);
        result_t outs [$];
        result_t r;
        int s;
        int k;
        int h;
        int c;
        h = q_head[m][t];
        c = q_cnt[m][t];
        if (a == ACT_DISPATCH)
        begin
            if (c >= DEPTH)
            begin
                r = '{KIND_ERROR, t, 16'd0, 1'b0};
                outs.push_back(r);
            end
            else
            begin
                s = t * DEPTH + (h + c) % DEPTH;
                slot_id[m][s] = next_seq[m];
                slot_done[m][s] = 0;
                q_cnt[m][t] = c + 1;
                r = '{KIND_ASSIGN, t, next_seq[m], 1'b0};
                outs.push_back(r);
                next_seq[m] = next_seq[m] + 16'd1;
            end
        end
        else
        begin
            s = 0;
            for (k = 0; k < c; k++)
            begin
                s = t * DEPTH + (h + k) % DEPTH;
                if (!slot_done[m][s] && slot_id[m][s] == id)
                    break;
            end
            if (k == c)
            begin
                r = '{KIND_ERROR, t, id, 1'b0};
                outs.push_back(r);
            end
            else
            begin
                slot_done[m][s] = 1;
                while (c > 0 && outs.size() < MAX_RELEASE)
                begin
                    s = t * DEPTH + h;
                    if (!slot_done[m][s])
                        break;
                    slot_done[m][s] = 0;
                    r = '{KIND_RELEASE, t, slot_id[m][s], 1'b0};
                    outs.push_back(r);
                    h = (h + 1) % DEPTH;
                    c = c - 1;
                end
                q_head[m][t] = h;
                q_cnt[m][t] = c;
            end
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        if (m == 1)
            foreach (outs[i])
                expected_q.push_back(outs[i]);
    endfunction

    function automatic bit pick_queued(logic [2:0] t, bit want_done, output logic [15:0] id);
        logic [15:0] ids [$];
        int s;
        for (int k = 0; k < q_cnt[0][t]; k++)
        begin
            s = t * DEPTH + (q_head[0][t] + k) % DEPTH;
            if (slot_done[0][s] == want_done)
                ids.push_back(slot_id[0][s]);
        end
        id = 16'd0;
        if (ids.size() == 0)
            return 0;
        id = ids[$urandom_range(0, ids.size() - 1)];
        return 1;
    endfunction

    function automatic void add_job(action_t a, logic [2:0] t, logic [15:0] id, bit fast);
        job_t j;
        j = '{a, t, id, fast};
        job_q.push_back(j);
        tag_queue_step(0, a, t, id);
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(negedge clk)
    begin
        job_t j;
        if (rst_n)
        begin
            if (holding && took)
                holding = 0;
            took = 0;
            if (!holding)
            begin
                if (gap_left > 0 && !rush)
                    gap_left--;
                else if (job_q.size() > 0)
                begin
                    j = job_q.pop_front();
                    action <= j.action;
                    tag <= j.tag;
                    task_id <= j.task_id;
                    rush = j.rush;
                    holding = 1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(5, 15);
                        else
                            gap_left = $urandom_range(0, 3);
                    end
                end
                else
                    rush = 0;
            end
            in_valid <= holding;
        end
    end

    always @(negedge clk)
    begin
        bit s;
        if (mode_left == 0)
        begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        case (mode)
            0: s = 0;
            1: s = ($urandom_range(0, 2) == 0);
            default: s = ($urandom_range(0, 3) != 0);
        endcase
        if (rush)
            s = 0;
        out_stall <= s;
    end

    always @(posedge clk)
    begin
        result_t w;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report("result with nothing expected, id", out_id, 16'd0);
                else
                begin
                    w = expected_q.pop_front();
                    if (kind !== w.kind)
                        report("kind", 16'(kind), 16'(w.kind));
                    if (out_tag !== w.tag)
                        report("out_tag", 16'(out_tag), 16'(w.tag));
                    if (out_id !== w.id)
                        report("out_id", out_id, w.id);
                    if (last !== w.last)
                        report("last", 16'(last), 16'(w.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                tag_queue_step(1, action_t'(action), tag, task_id);
                took = 1;
            end
        end
    end

    initial
    begin
        logic [15:0] id;
        logic [2:0]  t;
        int          r;
        for (int m = 0; m < 2; m++)
        begin
            next_seq[m] = 16'd0;
            for (int i = 0; i < TAGS; i++)
            begin
                q_head[m][i] = 0;
                q_cnt[m][i] = 0;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_done[m][i] = 0;
                slot_id[m][i] = 16'd0;
            end
        end

        for (int i = 0; i < 9; i++)
            add_job(ACT_DISPATCH, 3'd0, 16'($urandom), 0);
        for (int i = 7; i >= 1; i--)
            add_job(ACT_COMPLETE, 3'd0, 16'(i), 0);
        add_job(ACT_COMPLETE, 3'd0, 16'd7, 0);
        add_job(ACT_COMPLETE, 3'd0, 16'd0, 0);
        add_job(ACT_COMPLETE, 3'd5, 16'hFFFF, 0);
        add_job(ACT_DISPATCH, 3'd7, 16'hFFFF, 0);
        add_job(ACT_DISPATCH, 3'd7, 16'd0, 0);
        add_job(ACT_COMPLETE, 3'd7, 16'd8, 0);
        add_job(ACT_COMPLETE, 3'd7, 16'd8, 0);

        for (int i = 0; i < 480; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                t = 3'($urandom_range(0, 7));
            else
                t = 3'($urandom_range(0, 2));
            if (r < 50)
                add_job(ACT_DISPATCH, t, 16'($urandom), 0);
            else if (r < 90)
            begin
                if (pick_queued(t, 0, id))
                    add_job(ACT_COMPLETE, t, id, 0);
                else
                    add_job(ACT_DISPATCH, t, 16'($urandom), 0);
            end
            else if (r < 95 && pick_queued(t, 1, id))
                add_job(ACT_COMPLETE, t, id, 0);
            else
                add_job(ACT_COMPLETE, t, 16'($urandom), 0);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (job_q.size() > 0 || holding)
            @(posedge clk);
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
